>>> rtl/spf_pkg.sv
// spf_pkg: shared constants and types for the signal packet framer
// frame marker bytes, header mask, payload limit default and the output slot type
// no dependencies
package spf_pkg;

	// frame marker and trailer bytes
	localparam logic [7:0] START_BYTE = 8'h53;
	localparam logic [7:0] CR_BYTE    = 8'h0D;
	localparam logic [7:0] LF_BYTE    = 8'h0A;

	// header length field mask and element-size field position
	localparam logic [7:0] HDR_LEN_MASK = 8'h1F;
	localparam int unsigned SHIFT_LSB   = 5;

	// default payload limit in bytes (range 1 to 31)
	localparam int unsigned MAX_PAYLOAD_DEF = 26;

	// longest burst one transfer can cause: marker, header, byte, checksum, cr, lf
	localparam int unsigned SLOT_COUNT = 7;

	// one queued frame byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

endpackage

>>> rtl/signal_packet_framer.sv
// signal_packet_framer: wraps payload bytes in serial frames with header and checksum
// frame is marker 'S', header, payload, 16-bit checksum high byte first, cr, lf
// depends on spf_pkg
//
// usage
//   s_axis carries input transfers: type byte, element count and one payload byte.
//   the first transfer of a packet sets the length (count << type[6:5], clipped to
//   MAX_PAYLOAD) and also carries the first payload byte; a zero-length packet puts
//   out its whole frame on that transfer and drops its data byte.
//   m_axis carries frame bytes one per transfer, tlast high on the closing lf.
//   the first byte of a transfer's output is valid in the cycle after it is taken.
//   in mid-packet one payload byte is taken per cycle while the receiver is ready;
//   a packet start puts out three bytes (marker, header, byte) and a packet end five,
//   and s_axis_tready stays low until the last of those bytes is being taken.
//   the rate is set by the 7-slot output shift buffer, which drains one byte a cycle
//   while m_axis_tready is high; a new transfer is taken in the cycle the last byte leaves.
//   reset clears the packet state and empties the buffer; the next transfer starts
//   a packet. when the receiver stalls, the buffer holds and s_axis_tready stays low
//   while any byte is queued.
module signal_packet_framer #(
	parameter int unsigned MAX_PAYLOAD = spf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: type_byte [7:0], element_count [12:8], data_byte [20:13], zero [23:21]
	input  logic [23:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: out_byte [7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic        m_axis_tlast
);
	import spf_pkg::*;

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
	localparam int unsigned CntW  = $clog2(SLOT_COUNT + 1);

	// input fields
	logic [7:0] type_byte;
	logic [4:0] element_count;
	logic [7:0] data_byte;

	assign type_byte     = s_axis_tdata[7:0];
	assign element_count = s_axis_tdata[12:8];
	assign data_byte     = s_axis_tdata[20:13];

	// packet state
	logic        busy_q;
	logic [4:0]  left_q;
	logic [15:0] sum_q;
	logic [7:0]  pend_q;
	logic        odd_q;

	// output shift buffer, slot 0 is on the bus
	frame_byte_t         slot_q [SLOT_COUNT];
	logic [CntW-1:0]     cnt_q;

	logic s_accept;
	logic m_accept;

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = slot_q[0].data;
	assign m_axis_tlast  = slot_q[0].last;
	assign m_accept      = m_axis_tvalid & m_axis_tready;
	assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready);
	assign s_accept      = s_axis_tvalid & s_axis_tready;

	// length from count and element size, clipped
	logic [7:0]  len_full;
	logic [4:0]  len_clip;
	logic [7:0]  hdr_byte;

	always_comb begin
		len_full = {3'b000, element_count} << type_byte[SHIFT_LSB+1:SHIFT_LSB];
		len_clip = (len_full > MaxLen) ? MaxLen[4:0] : len_full[4:0];
		hdr_byte = type_byte | ({3'b000, len_clip} & HDR_LEN_MASK);
	end

	// checksum step for this payload byte
	logic        start;
	logic        zero_len;
	logic [4:0]  left_base;
	logic [15:0] sum_base;
	logic [7:0]  pend_base;
	logic        odd_base;
	logic [4:0]  left_nxt;
	logic [15:0] sum_nxt;
	logic [7:0]  pend_nxt;
	logic        odd_nxt;
	logic [15:0] sum_fin;
	logic        last_byte;

	always_comb begin
		start     = !busy_q;
		zero_len  = start && (len_clip == '0);
		left_base = start ? len_clip : left_q;
		sum_base  = start ? 16'h0000 : sum_q;
		pend_base = start ? 8'h00 : pend_q;
		odd_base  = start ? 1'b0 : odd_q;
		left_nxt  = left_base - 5'd1;
		last_byte = (left_nxt == '0);
		// a completed pair, or an odd last byte padded with a zero low byte
		sum_fin   = odd_base ? (sum_base + {pend_base, data_byte})
		                     : (sum_base + {data_byte, 8'h00});
		if (odd_base) begin
			sum_nxt  = sum_fin;
			pend_nxt = pend_base;
			odd_nxt  = 1'b0;
		end else begin
			sum_nxt  = sum_base;
			pend_nxt = data_byte;
			odd_nxt  = 1'b1;
		end
	end

	// bytes that this transfer puts out
	frame_byte_t     load [SLOT_COUNT];
	logic [CntW-1:0] load_cnt;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			load[i] = '{data: 8'h00, last: 1'b0};
		end
		case ({zero_len, start, last_byte})
			3'b110, 3'b111: begin
				load[0]  = '{data: START_BYTE, last: 1'b0};
				load[1]  = '{data: hdr_byte, last: 1'b0};
				load[2]  = '{data: 8'h00, last: 1'b0};
				load[3]  = '{data: 8'h00, last: 1'b0};
				load[4]  = '{data: CR_BYTE, last: 1'b0};
				load[5]  = '{data: LF_BYTE, last: 1'b1};
				load_cnt = CntW'(6);
			end
			3'b011: begin
				load[0]  = '{data: START_BYTE, last: 1'b0};
				load[1]  = '{data: hdr_byte, last: 1'b0};
				load[2]  = '{data: data_byte, last: 1'b0};
				load[3]  = '{data: sum_fin[15:8], last: 1'b0};
				load[4]  = '{data: sum_fin[7:0], last: 1'b0};
				load[5]  = '{data: CR_BYTE, last: 1'b0};
				load[6]  = '{data: LF_BYTE, last: 1'b1};
				load_cnt = CntW'(7);
			end
			3'b010: begin
				load[0]  = '{data: START_BYTE, last: 1'b0};
				load[1]  = '{data: hdr_byte, last: 1'b0};
				load[2]  = '{data: data_byte, last: 1'b0};
				load_cnt = CntW'(3);
			end
			3'b001: begin
				load[0]  = '{data: data_byte, last: 1'b0};
				load[1]  = '{data: sum_fin[15:8], last: 1'b0};
				load[2]  = '{data: sum_fin[7:0], last: 1'b0};
				load[3]  = '{data: CR_BYTE, last: 1'b0};
				load[4]  = '{data: LF_BYTE, last: 1'b1};
				load_cnt = CntW'(5);
			end
			default: begin
				load[0]  = '{data: data_byte, last: 1'b0};
				load_cnt = CntW'(1);
			end
		endcase
	end

	// packet state update on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			sum_q  <= '0;
			pend_q <= '0;
			odd_q  <= 1'b0;
		end else if (s_accept) begin
			if (zero_len || last_byte) begin
				busy_q <= 1'b0;
				left_q <= '0;
				sum_q  <= '0;
				pend_q <= '0;
				odd_q  <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				left_q <= left_nxt;
				sum_q  <= sum_nxt;
				pend_q <= pend_nxt;
				odd_q  <= odd_nxt;
			end
		end
	end

	// buffer fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_accept) begin
			cnt_q <= load_cnt;
		end else if (m_accept) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	// buffer contents: load a burst or shift toward slot 0
	always_ff @(posedge clk) begin
		if (s_accept) begin
			slot_q <= load;
		end else if (m_accept) begin
			for (int i = 0; i < SLOT_COUNT - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
			slot_q[SLOT_COUNT-1] <= '{data: 8'h00, last: 1'b0};
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(SLOT_COUNT))
		else $error("output buffer count out of range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_axis_tvalid)
		else $error("input transfer produced no output byte");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == LF_BYTE))
		else $error("frame end not on lf byte");

	a_busy_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (left_q != '0))
		else $error("packet open with no bytes left");

endmodule

>>> sim/signal_packet_framer_tb.sv
// signal_packet_framer_tb: self-checking testbench for the signal packet framer
// directed table then random packets under several idle/stall phases, checked by a frame predictor
// depends on spf_pkg and signal_packet_framer
`timescale 1ns / 100ps

module signal_packet_framer_tb;
	import spf_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned PHASE_ITEMS  = 25;
	localparam int unsigned LONG_HOLD    = 60;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned NUM_ROWS     = 14;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic [23:0] s_axis_tdata  = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic        m_axis_tlast;

	signal_packet_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast)
	);

	// directed stimulus row; header and checksum are typed in where obvious
	typedef struct packed {
		logic [7:0]  sig_type;
		logic [4:0]  elem_count;
		logic [7:0]  payload;
		logic        hdr_known;
		logic [7:0]  hdr;
		logic        sum_known;
		logic [15:0] sum;
	} stim_row_t;

	stim_row_t directed_rows [NUM_ROWS] = '{
		// empty packet, data byte dropped
		'{8'h00, 5'd0,  8'hFF, 1'b1, 8'h00, 1'b1, 16'h0000},
		// empty packet with every type bit set
		'{8'hFF, 5'd0,  8'h00, 1'b1, 8'hFF, 1'b1, 16'h0000},
		// single byte packet, whole frame on one transfer
		'{8'h01, 5'd1,  8'hFF, 1'b1, 8'h01, 1'b1, 16'hFF00},
		'{8'h9F, 5'd1,  8'h00, 1'b1, 8'h9F, 1'b1, 16'h0000},
		// two byte elements
		'{8'h20, 5'd1,  8'hAB, 1'b1, 8'h22, 1'b0, 16'h0000},
		'{8'h00, 5'd0,  8'hCD, 1'b0, 8'h00, 1'b1, 16'hABCD},
		// four byte elements, checksum wraps, noise on the continuation fields
		'{8'h40, 5'd1,  8'hFF, 1'b1, 8'h44, 1'b0, 16'h0000},
		'{8'hFF, 5'd31, 8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000},
		'{8'h00, 5'd0,  8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000},
		'{8'h00, 5'd0,  8'hFF, 1'b0, 8'h00, 1'b1, 16'hFFFE},
		// odd length, last byte padded low
		'{8'h1C, 5'd3,  8'h12, 1'b1, 8'h1F, 1'b0, 16'h0000},
		'{8'hE0, 5'd0,  8'h34, 1'b0, 8'h00, 1'b0, 16'h0000},
		'{8'h00, 5'd0,  8'h56, 1'b0, 8'h00, 1'b1, 16'h6834},
		// overlong, clipped to the payload limit; the rest follows in the random part
		'{8'h60, 5'd31, 8'h5A, 1'b1, 8'h7A, 1'b0, 16'h0000}
	};

	// predictor state
	logic        pk_busy = 1'b0;
	logic [4:0]  pk_left = '0;
	logic [15:0] pk_sum  = '0;
	logic [7:0]  pk_high = '0;
	logic        pk_odd  = 1'b0;

	frame_byte_t expected_bytes [$];
	frame_byte_t latest_burst [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int errors         = 0;
	int n_packets      = 0;
	int n_empty        = 0;
	int n_clipped      = 0;
	int n_inputs       = 0;
	int n_checked      = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_byte(input logic [7:0] b, input logic last);
		frame_byte_t fb;
		fb.data = b;
		fb.last = last;
		latest_burst.push_back(fb);
		expected_bytes.push_back(fb);
	endfunction

	// checksum, cr, lf, then back to idle
	function automatic void close_frame();
		logic [15:0] total;
		total = pk_sum + (pk_odd ? {pk_high, 8'h00} : 16'h0000);
		queue_byte(total[15:8], 1'b0);
		queue_byte(total[7:0], 1'b0);
		queue_byte(CR_BYTE, 1'b0);
		queue_byte(LF_BYTE, 1'b1);
		pk_busy = 1'b0;
		pk_left = '0;
		pk_sum  = '0;
		pk_high = '0;
		pk_odd  = 1'b0;
	endfunction

	// frame bytes caused by one accepted transfer
	task automatic frame_step(input logic [7:0] t, input logic [4:0] c, input logic [7:0] d);
		int unsigned len;
		latest_burst.delete();
		if (!pk_busy) begin
			len = {27'd0, c} << t[SHIFT_LSB +: 2];
			n_packets++;
			if (len > MAX_PAYLOAD_DEF) begin
				len = MAX_PAYLOAD_DEF;
				n_clipped++;
			end
			pk_sum  = '0;
			pk_high = '0;
			pk_odd  = 1'b0;
			queue_byte(START_BYTE, 1'b0);
			queue_byte(t | (len[7:0] & HDR_LEN_MASK), 1'b0);
			if (len == 0) begin
				n_empty++;
				close_frame();
				return;
			end
			pk_busy = 1'b1;
			pk_left = len[4:0];
		end
		queue_byte(d, 1'b0);
		if (!pk_odd) begin
			pk_high = d;
			pk_odd  = 1'b1;
		end else begin
			pk_sum = pk_sum + {pk_high, d};
			pk_odd = 1'b0;
		end
		pk_left = pk_left - 5'd1;
		if (pk_left == 0)
			close_frame();
	endtask

	// offer one transfer, with random gaps before it; returns at the next falling edge
	task automatic push_item(input logic [7:0] t, input logic [4:0] c, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {3'b000, d, c, t};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_inputs++;
		frame_step(t, c, d);
		@(negedge clk);
	endtask

	// random well-formed packet content; continuation fields are noise
	task automatic push_random();
		logic [7:0] t;
		logic [4:0] c;
		int         r;
		t = 8'($urandom_range(255));
		c = 5'($urandom_range(31));
		if (!pk_busy) begin
			r = $urandom_range(99);
			if (r < 10)
				c = 5'd0;
			else if (r < 20)
				c = 5'($urandom_range(31, 27));
			else
				c = 5'($urandom_range(6, 1));
		end
		push_item(t, c, 8'($urandom_range(255)));
	endtask

	// sender pause until every expected byte has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (expected_bytes.size() != 0);
	endtask

	// receiver: random stalls plus one long hold-off at the start of the first random phase
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// output checker
	always @(posedge clk) begin
		frame_byte_t exp_b;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected frame byte, expected none, got %02h last %0b",
					$time, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				exp_b = expected_bytes.pop_front();
				n_checked++;
				if (m_axis_tdata !== exp_b.data) begin
					$display("%0t: out_byte mismatch, expected %02h, got %02h",
						$time, exp_b.data, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== exp_b.last) begin
					$display("%0t: frame_end mismatch, expected %0b, got %0b",
						$time, exp_b.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("[signal_packet_framer] ERROR");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		int phase_send [4];
		int phase_recv [4];
		int sz;
		logic [15:0] got_sum;
		phase_send = '{0, 50, 0, 16};
		phase_recv = '{0, 0, 50, 16};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < NUM_ROWS; i++) begin
			push_item(directed_rows[i].sig_type, directed_rows[i].elem_count,
				directed_rows[i].payload);
			sz = latest_burst.size();
			if (directed_rows[i].hdr_known && latest_burst[1].data !== directed_rows[i].hdr) begin
				$display("%0t: header of row %0d, expected %02h, got %02h",
					$time, i, directed_rows[i].hdr, latest_burst[1].data);
				errors++;
			end
			if (directed_rows[i].sum_known) begin
				got_sum = {latest_burst[sz-4].data, latest_burst[sz-3].data};
				if (!latest_burst[sz-1].last || got_sum !== directed_rows[i].sum) begin
					$display("%0t: checksum of row %0d, expected %04h, got %04h",
						$time, i, directed_rows[i].sum, got_sum);
					errors++;
				end
			end
		end

		// random phases, each ending in a pause until the frames are out
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_recv[ph];
			if (ph == 0)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++)
				push_random();
			while (pk_busy)
				push_random();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$display("%0t: %0d frame bytes never came out, expected %02h first",
				$time, expected_bytes.size(), expected_bytes[0].data);
			errors++;
		end

		$display("covered %0d packets (%0d empty, %0d clipped) from %0d input transfers",
			n_packets, n_empty, n_clipped, n_inputs);
		$display("checked %0d frame bytes under four idle/stall mixes, %0d errors",
			n_checked, errors);
		if (errors == 0)
			$display("[signal_packet_framer] OK");
		else
			$display("[signal_packet_framer] ERROR");
		$finish;
	end

endmodule
